### hw/rtl/apr_pkg.sv
// shared types and status codes for the adjacent pair resource scheduler
package apr_pkg;

    // per-seat status codes reported on the result ports
    localparam logic [2:0] ST_THINKING      = 3'd0;
    localparam logic [2:0] ST_WAITING       = 3'd1;
    localparam logic [2:0] ST_STARTED       = 3'd2;
    localparam logic [2:0] ST_EATING        = 3'd3;
    localparam logic [2:0] ST_FINISHED_NOW  = 3'd4;
    localparam logic [2:0] ST_FINISHED_EARL = 3'd5;

    // request opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // reset value of the active seat count
    localparam logic [4:0] ACTIVE_COUNT_RESET = 5'd5;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // write one seat's times and clear its flags
        logic exec;   // evaluate the current seat and emit its status
    } apr_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic last_seat;  // current seat is the last active one
    } apr_stat_t;

endpackage

### hw/rtl/adjacent_pair_resource_scheduler.sv
// top level of the adjacent pair resource scheduler
// A request is taken when start is high and busy is low. A load request (op 0)
// writes one seat's arrival and duration in the cycle it is taken and leaves
// busy low, so requests can follow every cycle. A tick request (op 1) scans
// the active seats in order, their count clamped to 1..SEATS; busy stays high
// until the last seat is evaluated. Each seat is first read from the seat
// stores (registered read) in a fetch state and then evaluated in an exec
// state.
// One status line per seat appears on the result ports for exactly one cycle,
// marked by strobe; the receiver must take each one as it comes, there is no
// back pressure. The last line of a tick carries last and all_done.
// cfg_ready is always high; write active_count only while idle.
module adjacent_pair_resource_scheduler #(
    parameter int SEATS     = 16,
    parameter int TIME_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [3:0]  seat,
    input  logic [15:0] arrival,
    input  logic [15:0] duration,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    output logic        strobe,
    output logic [3:0]  seat_out,
    output logic [2:0]  status,
    output logic [15:0] tick_time,
    output logic        last,
    output logic        all_done
);
    import apr_pkg::*;

    apr_cmd_t                 cmd;
    apr_stat_t                stat;
    logic [$clog2(SEATS)-1:0] idx;

    assign cfg_ready = 1'b1;

    // controller
    apr_ctrl #(
        .SEATS (SEATS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .idx   (idx),
        .busy  (busy)
    );

    // datapath
    apr_datapath #(
        .SEATS     (SEATS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .idx       (idx),
        .stat      (stat),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .seat      (seat),
        .arrival   (arrival),
        .duration  (duration),
        .strobe    (strobe),
        .seat_out  (seat_out),
        .status    (status),
        .tick_time (tick_time),
        .last      (last),
        .all_done  (all_done)
    );

endmodule

### hw/rtl/apr_ram.sv
// generic single write port ram with registered read
module apr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/apr_ctrl.sv
// controller state machine: accepts requests and sequences the seat scan
module apr_ctrl #(
    parameter int SEATS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     op,
    input  apr_pkg::apr_stat_t       stat,
    output apr_pkg::apr_cmd_t        cmd,
    output logic [$clog2(SEATS)-1:0] idx,
    output logic                     busy
);
    import apr_pkg::*;

    localparam int IDX_BITS = $clog2(SEATS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic                busy_reg, busy_next;

    // next state and seat counter
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && (op == OP_TICK))
                begin
                    state_next = S_FETCH;
                    idx_next   = '0;
                end
            end
            S_FETCH:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.last_seat)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_FETCH;
                    idx_next   = idx_reg + IDX_BITS'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            busy_reg  <= busy_next;
        end
    end

    // commands to the datapath
    always_comb
    begin
        cmd.load = (state_reg == S_IDLE) && start && (op == OP_LOAD);
        cmd.exec = (state_reg == S_EXEC);
    end

    assign idx  = idx_reg;
    assign busy = busy_reg;

endmodule

### hw/rtl/apr_datapath.sv
// datapath: seat stores, resource and seat flags, time counter, result registers
module apr_datapath #(
    parameter int SEATS     = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  apr_pkg::apr_cmd_t        cmd,
    input  logic [$clog2(SEATS)-1:0] idx,
    output apr_pkg::apr_stat_t       stat,
    input  logic                     cfg_valid,
    input  logic [4:0]               cfg_data,
    input  logic [3:0]               seat,
    input  logic [15:0]              arrival,
    input  logic [15:0]              duration,
    output logic                     strobe,
    output logic [3:0]               seat_out,
    output logic [2:0]               status,
    output logic [15:0]              tick_time,
    output logic                     last,
    output logic                     all_done
);
    import apr_pkg::*;

    localparam int IDX_BITS = $clog2(SEATS);
    localparam int CNT_BITS = $clog2(SEATS + 1);
    localparam int CMP_BITS = (TIME_BITS > 16) ? TIME_BITS : 16;

    logic [4:0]           active_count_reg;
    logic [SEATS-1:0]     held_reg, held_next;
    logic [SEATS-1:0]     eat_reg, eat_next;
    logic [SEATS-1:0]     done_reg, done_next;
    logic [TIME_BITS-1:0] time_reg, time_next;

    logic                 strobe_reg;
    logic [3:0]           seat_out_reg;
    logic [2:0]           status_reg, status_next;
    logic [15:0]          tick_time_reg;
    logic                 last_reg;
    logic                 all_done_reg, all_done_next;

    logic [CNT_BITS-1:0]  n_eff;
    logic                 last_seat;
    logic [IDX_BITS-1:0]  nx;
    logic [SEATS-1:0]     active_mask;
    logic [31:0]          seat_wide;
    logic                 seat_ok;
    logic [IDX_BITS-1:0]  seat_idx;
    logic [15:0]          arr_rd, rem_rd;
    logic                 rem_dec;
    logic                 rem_we;
    logic [IDX_BITS-1:0]  rem_waddr;
    logic [15:0]          rem_wdata;
    logic [31:0]          idx_wide;
    logic [31:0]          time_wide;

    // configuration register, always ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count_reg <= ACTIVE_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            active_count_reg <= cfg_data;
        end
    end

    // clamp the active count to 1..SEATS
    always_comb
    begin
        if (active_count_reg == 5'd0)
        begin
            n_eff = CNT_BITS'(1);
        end
        else if (32'(active_count_reg) > SEATS)
        begin
            n_eff = CNT_BITS'(SEATS);
        end
        else
        begin
            n_eff = CNT_BITS'(active_count_reg);
        end
    end

    // last seat and neighbor index
    assign last_seat      = ((CNT_BITS'(idx) + CNT_BITS'(1)) == n_eff);
    assign nx             = last_seat ? '0 : (idx + IDX_BITS'(1));
    assign stat.last_seat = last_seat;

    always_comb
    begin
        for (int j = 0; j < SEATS; j++)
        begin
            active_mask[j] = (j < 32'(n_eff));
        end
    end

    // load address check
    assign seat_wide = 32'(seat);
    assign seat_ok   = (seat_wide < SEATS);
    assign seat_idx  = seat_wide[IDX_BITS-1:0];

    // seat evaluation and flag updates
    always_comb
    begin
        held_next     = held_reg;
        eat_next      = eat_reg;
        done_next     = done_reg;
        time_next     = time_reg;
        status_next   = ST_THINKING;
        rem_dec       = 1'b0;
        all_done_next = 1'b0;
        if (cmd.load && seat_ok)
        begin
            eat_next[seat_idx]  = 1'b0;
            done_next[seat_idx] = 1'b0;
        end
        if (cmd.exec)
        begin
            if (done_reg[idx])
            begin
                status_next = ST_FINISHED_EARL;
            end
            else if (CMP_BITS'(arr_rd) > CMP_BITS'(time_reg))
            begin
                status_next = ST_THINKING;
            end
            else if (rem_rd == 16'd0)
            begin
                if (eat_reg[idx])
                begin
                    held_next[idx] = 1'b0;
                    held_next[nx]  = 1'b0;
                end
                eat_next[idx]  = 1'b0;
                done_next[idx] = 1'b1;
                status_next    = ST_FINISHED_NOW;
            end
            else if (eat_reg[idx])
            begin
                rem_dec     = 1'b1;
                status_next = ST_EATING;
            end
            else if (held_reg[idx] || held_reg[nx])
            begin
                status_next = ST_WAITING;
            end
            else
            begin
                held_next[idx] = 1'b1;
                held_next[nx]  = 1'b1;
                eat_next[idx]  = 1'b1;
                rem_dec        = 1'b1;
                status_next    = ST_STARTED;
            end
            if (last_seat)
            begin
                all_done_next = &(done_next | ~active_mask);
                if (time_reg != {TIME_BITS{1'b1}})
                begin
                    time_next = time_reg + TIME_BITS'(1);
                end
            end
        end
    end

    // control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            eat_reg    <= '0;
            done_reg   <= '0;
            time_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            held_reg   <= held_next;
            eat_reg    <= eat_next;
            done_reg   <= done_next;
            time_reg   <= time_next;
            strobe_reg <= cmd.exec;
        end
    end

    assign idx_wide  = 32'(idx);
    assign time_wide = 32'(time_reg);

    // result payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            seat_out_reg  <= idx_wide[3:0];
            status_reg    <= status_next;
            tick_time_reg <= time_wide[15:0];
            last_reg      <= last_seat;
            all_done_reg  <= all_done_next;
        end
    end

    // remaining time store write mux: load or countdown
    assign rem_we    = (cmd.load && seat_ok) || rem_dec;
    assign rem_waddr = cmd.load ? seat_idx : idx;
    assign rem_wdata = cmd.load ? duration : (rem_rd - 16'd1);

    apr_ram #(
        .WIDTH (16),
        .DEPTH (SEATS)
    ) u_arrival_ram (
        .clk   (clk),
        .we    (cmd.load && seat_ok),
        .waddr (seat_idx),
        .wdata (arrival),
        .raddr (idx),
        .rdata (arr_rd)
    );

    apr_ram #(
        .WIDTH (16),
        .DEPTH (SEATS)
    ) u_remaining_ram (
        .clk   (clk),
        .we    (rem_we),
        .waddr (rem_waddr),
        .wdata (rem_wdata),
        .raddr (idx),
        .rdata (rem_rd)
    );

    assign strobe    = strobe_reg;
    assign seat_out  = seat_out_reg;
    assign status    = status_reg;
    assign tick_time = tick_time_reg;
    assign last      = last_reg;
    assign all_done  = all_done_reg;

endmodule
